### rtl/core/bse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bubble sort engine package
// Shared constants, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int unsigned BSE_MAX_ITEMS  = 64;
  localparam int unsigned BSE_VALUE_BITS = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_FIRST,
    ST_PASS_STEP,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } bse_state_e;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic carry_ld;
    logic step;
    logic pass_end;
    logic emit_start;
    logic emit_rd;
    logic emit_ld;
    logic emit_next;
    logic batch_done;
  } bse_cmd_t;

  typedef struct packed {
    logic sort_needed;
    logic step_last;
    logic passes_done;
    logic emit_final;
  } bse_sts_t;

endpackage
`default_nettype wire

### rtl/core/bse_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bubble sort engine channels
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface bse_in_if #(
  parameter int unsigned VALUE_BITS = bse_pkg::BSE_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bse_out_if #(
  parameter int unsigned VALUE_BITS = bse_pkg::BSE_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sorted_value;
  logic                         final_res;
  logic                         overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

interface bse_cfg_if;
  logic valid;
  logic ready;
  logic descending;

  modport source (output valid, output descending, input ready);
  modport sink   (input valid, input descending, output ready);
endinterface
`default_nettype wire

### rtl/core/bse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/bse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bubble sort engine controller
// Sequences load, sort passes and result emission of one batch.
// ----------------------------------------------------------------------------
module bse_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  input  wire logic              out_ready_i,
  input  wire bse_pkg::bse_sts_t sts_i,
  output logic                   in_ready_o,
  output bse_pkg::bse_cmd_t      cmd_o
);
  import bse_pkg::*;

  bse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            if (sts_i.sort_needed) begin
              cmd_o.sort_start = 1'b1;
              state_d          = ST_PASS_FIRST;
            end else begin
              cmd_o.emit_start = 1'b1;
              state_d          = ST_EMIT_RD;
            end
          end
        end
      end
      ST_PASS_FIRST: begin
        cmd_o.carry_ld = 1'b1;
        state_d        = ST_PASS_STEP;
      end
      ST_PASS_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last) begin
          state_d = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        cmd_o.pass_end = 1'b1;
        if (sts_i.passes_done) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_EMIT_RD;
        end else begin
          state_d = ST_PASS_FIRST;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_ready_i) begin
          if (sts_i.emit_final) begin
            cmd_o.batch_done = 1'b1;
            state_d          = ST_LOAD;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/bse_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bubble sort engine datapath
// Element store, counters, bubble carry register and result register.
// ----------------------------------------------------------------------------
module bse_dpath #(
  parameter int unsigned MaxItems  = bse_pkg::BSE_MAX_ITEMS,
  parameter int unsigned ValueBits = bse_pkg::BSE_VALUE_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bse_pkg::bse_cmd_t           cmd_i,
  output bse_pkg::bse_sts_t                sts_o,
  input  wire logic signed [ValueBits-1:0] in_value_i,
  input  wire logic                        in_last_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_desc_i,
  output logic                             cfg_ready_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic signed [ValueBits-1:0]      out_value_o,
  output logic                             out_final_o,
  output logic                             out_ovf_o
);
  import bse_pkg::*;

  localparam int unsigned IW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);

  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  pass_q, pass_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           ovf_q, ovf_d;
  logic           desc_q, desc_d;
  logic           order_q, order_d;
  logic           out_vld_q, out_vld_d;

  logic signed [ValueBits-1:0] carry_q, carry_d;
  logic signed [ValueBits-1:0] out_value_q, out_value_d;
  logic                        out_final_q, out_final_d;
  logic                        out_ovf_q, out_ovf_d;

  logic                 full;
  logic                 we;
  logic [IW-1:0]        waddr, raddr, src;
  logic [ValueBits-1:0] wdata, rdata;
  logic signed [ValueBits-1:0] rdata_s;
  logic                 carry_gt;

  assign full     = (count_q == CW'(MaxItems));
  assign rdata_s  = $signed(rdata);
  assign carry_gt = (carry_q > rdata_s);
  assign src      = order_q ? IW'(count_q - CW'(1) - CW'(idx_q)) : idx_q;

  assign sts_o.sort_needed = (count_q != '0);
  assign sts_o.step_last   = ((CW'(idx_q) + CW'(2)) == count_q);
  assign sts_o.passes_done = ((pass_q + CW'(2)) == count_q);
  assign sts_o.emit_final  = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = carry_q;
    priority if (cmd_i.load) begin
      we    = !full;
      waddr = IW'(count_q);
      wdata = in_value_i;
    end else if (cmd_i.step) begin
      we    = 1'b1;
      wdata = carry_gt ? rdata : carry_q;
    end else if (cmd_i.pass_end) begin
      we    = 1'b1;
    end else begin
      we    = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd_i.emit_rd) begin
      raddr = src;
    end else if (cmd_i.step) begin
      raddr = idx_q + IW'(2);
    end else if (cmd_i.carry_ld) begin
      raddr = idx_q + IW'(1);
    end else begin
      raddr = '0;
    end
  end

  bse_ram #(
    .WIDTH(ValueBits),
    .DEPTH(MaxItems)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d     = count_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    desc_d      = desc_q;
    order_d     = order_q;
    out_vld_d   = out_vld_q;
    carry_d     = carry_q;
    out_value_d = out_value_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    if (cfg_valid_i) begin
      desc_d = cfg_desc_i;
    end
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
      if (in_last_i) begin
        order_d = desc_q;
      end
    end
    if (cmd_i.sort_start) begin
      pass_d = '0;
      idx_d  = '0;
    end
    if (cmd_i.carry_ld) begin
      carry_d = rdata_s;
    end
    if (cmd_i.step) begin
      idx_d = idx_q + IW'(1);
      if (!carry_gt) begin
        carry_d = rdata_s;
      end
    end
    if (cmd_i.pass_end) begin
      pass_d = pass_q + CW'(1);
      idx_d  = '0;
    end
    if (cmd_i.emit_start) begin
      idx_d = '0;
    end
    if (cmd_i.emit_ld) begin
      out_value_d = rdata_s;
      out_final_d = sts_o.emit_final;
      out_ovf_d   = ovf_q;
      out_vld_d   = 1'b1;
    end
    if (cmd_i.emit_next) begin
      idx_d     = idx_q + IW'(1);
      out_vld_d = 1'b0;
    end
    if (cmd_i.batch_done) begin
      count_d   = '0;
      ovf_d     = 1'b0;
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pass_q    <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
      desc_q    <= 1'b0;
      order_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      pass_q    <= pass_d;
      idx_q     <= idx_d;
      ovf_q     <= ovf_d;
      desc_q    <= desc_d;
      order_q   <= order_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q     <= carry_d;
    out_value_q <= out_value_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_value_o = out_value_q;
  assign out_final_o = out_final_q;
  assign out_ovf_o   = out_ovf_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxItems))
    else $error("item count above capacity");

  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (count_q != '0))
    else $error("result offered for empty batch");

  a_pass_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pass_end |-> ((CW'(idx_q) + CW'(1)) == count_q))
    else $error("pass closed at wrong position");

  a_hold_while_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_value_q)))
    else $error("result word changed while stalled");

endmodule
`default_nettype wire

### rtl/core/bubble_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bubble sort engine
// Collects a batch of signed words, bubble sorts it and streams it back.
// ----------------------------------------------------------------------------
// Input words load at one per cycle until the word flagged last; words beyond
// MAX_ITEMS are dropped and flag overflow on every result of the batch. A
// batch of n stored words then takes (n-1) passes, in which the element
// store's single read port feeds one compare-and-swap per cycle. Each result
// is then read from the store, loaded and held until the output takes it. The
// descending bit is sampled when the last word of a batch is accepted.
module bubble_sort_engine #(
  parameter int unsigned MAX_ITEMS  = bse_pkg::BSE_MAX_ITEMS,
  parameter int unsigned VALUE_BITS = bse_pkg::BSE_VALUE_BITS
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  bse_in_if.sink   in_i,
  bse_out_if.source out_o,
  bse_cfg_if.sink  cfg_i
);
  import bse_pkg::*;

  bse_cmd_t cmd;
  bse_sts_t sts;
  logic     in_ready;

  bse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  bse_dpath #(
    .MaxItems (MAX_ITEMS),
    .ValueBits(VALUE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_value_i (in_i.value),
    .in_last_i  (in_i.last),
    .cfg_valid_i(cfg_i.valid),
    .cfg_desc_i (cfg_i.descending),
    .cfg_ready_o(cfg_i.ready),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .out_value_o(out_o.sorted_value),
    .out_final_o(out_o.final_res),
    .out_ovf_o  (out_o.overflow)
  );

  assign in_i.ready = in_ready;

endmodule
`default_nettype wire
